// ===== sv/hvcps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the HV contactor precharge sequencer.
// No dependencies; used by every module of the block.

package hvcps_pkg;

    // sequencer state codes
    localparam logic [3:0] ST_OPEN    = 4'd0;
    localparam logic [3:0] ST_C_S1    = 4'd1;
    localparam logic [3:0] ST_C_S2    = 4'd2;
    localparam logic [3:0] ST_C_PRE   = 4'd3;
    localparam logic [3:0] ST_C_CLOSE = 4'd4;
    localparam logic [3:0] ST_C_ARMED = 4'd5;
    localparam logic [3:0] ST_C_WAIT  = 4'd6;
    localparam logic [3:0] ST_D_S1    = 4'd7;
    localparam logic [3:0] ST_D_PRE   = 4'd8;
    localparam logic [3:0] ST_D_CLOSE = 4'd9;
    localparam logic [3:0] ST_D_ARMED = 4'd10;
    localparam logic [3:0] ST_D_WAIT  = 4'd11;
    localparam logic [3:0] ST_OPENING = 4'd12;
    localparam logic [3:0] ST_ERROR   = 4'd13;

    // item kinds
    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_START_CHG = 3'd1;
    localparam logic [2:0] KIND_START_DRV = 3'd2;
    localparam logic [2:0] KIND_OPEN      = 3'd3;
    localparam logic [2:0] KIND_EMERGENCY = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_CHG_ALLOW   = 3'd1;
    localparam logic [2:0] ERR_DRV_ALLOW   = 3'd2;
    localparam logic [2:0] ERR_BMS_ARMED   = 3'd3;
    localparam logic [2:0] ERR_PRE_TIMEOUT = 3'd4;
    localparam logic [2:0] ERR_CURRENT     = 3'd5;

    // contactor line bits
    localparam logic [3:0] LINE_MINUS = 4'b0001;
    localparam logic [3:0] LINE_PLUS  = 4'b0010;
    localparam logic [3:0] LINE_PRE   = 4'b0100;
    localparam logic [3:0] LINE_CHG   = 4'b1000;

    // register indexes
    localparam logic [2:0] REG_PRE_DELAY   = 3'd0;
    localparam logic [2:0] REG_PRE_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_ZC_TIMEOUT  = 3'd2;
    localparam logic [2:0] REG_ZC_THRESH   = 3'd3;
    localparam logic [2:0] REG_PRE_TOL     = 3'd4;
    localparam logic [2:0] REG_STEP_SETTLE = 3'd5;
    localparam logic [2:0] REG_CLOSE_SETTLE = 3'd6;

    localparam int ADDR_W = 5;

    typedef struct packed {
        logic [15:0] precharge_delay_ticks;
        logic [15:0] precharge_timeout_ticks;
        logic [15:0] zero_current_timeout_ticks;
        logic [14:0] zero_current_threshold;
        logic [15:0] bus_margin;
        logic [9:0]  step_settle_ticks;
        logic [9:0]  close_settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        immediate;
        logic        charge_allowed;
        logic        discharge_allowed;
        logic        bms_armed;
        logic [15:0] pack_voltage;
        logic [15:0] charger_bus_voltage;
        logic [15:0] inverter_bus_voltage;
        logic signed [15:0] pack_current;
    } item_t;

    typedef struct packed {
        logic [3:0]  state;
        logic [2:0]  fault;
        logic [15:0] elapsed;
        logic [3:0]  lines;
    } seq_t;

    typedef struct packed {
        logic [3:0] lines;
        logic [3:0] mode;
        logic [2:0] error_code;
        logic       accepted;
    } result_t;

endpackage

// ===== sv/hvcps_cfg_regs.sv =====
`timescale 1ns / 1ps
// APB register file holding the sequencer timing and threshold settings.
// Depends on hvcps_pkg.

module hvcps_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hvcps_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output hvcps_pkg::cfg_t               cfg
);

    hvcps_pkg::cfg_t cfg_reg;
    hvcps_pkg::cfg_t cfg_next;
    logic [2:0]      index;
    logic            wr_en;

    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                hvcps_pkg::REG_PRE_DELAY:    cfg_next.precharge_delay_ticks = pwdata[15:0];
                hvcps_pkg::REG_PRE_TIMEOUT:  cfg_next.precharge_timeout_ticks = pwdata[15:0];
                hvcps_pkg::REG_ZC_TIMEOUT:   cfg_next.zero_current_timeout_ticks = pwdata[15:0];
                hvcps_pkg::REG_ZC_THRESH:    cfg_next.zero_current_threshold = pwdata[14:0];
                hvcps_pkg::REG_PRE_TOL:      cfg_next.bus_margin = pwdata[15:0];
                hvcps_pkg::REG_STEP_SETTLE:  cfg_next.step_settle_ticks = pwdata[9:0];
                hvcps_pkg::REG_CLOSE_SETTLE: cfg_next.close_settle_ticks = pwdata[9:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            hvcps_pkg::REG_PRE_DELAY:    prdata = {16'd0, cfg_reg.precharge_delay_ticks};
            hvcps_pkg::REG_PRE_TIMEOUT:  prdata = {16'd0, cfg_reg.precharge_timeout_ticks};
            hvcps_pkg::REG_ZC_TIMEOUT:   prdata = {16'd0, cfg_reg.zero_current_timeout_ticks};
            hvcps_pkg::REG_ZC_THRESH:    prdata = {17'd0, cfg_reg.zero_current_threshold};
            hvcps_pkg::REG_PRE_TOL:      prdata = {16'd0, cfg_reg.bus_margin};
            hvcps_pkg::REG_STEP_SETTLE:  prdata = {22'd0, cfg_reg.step_settle_ticks};
            hvcps_pkg::REG_CLOSE_SETTLE: prdata = {22'd0, cfg_reg.close_settle_ticks};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.precharge_delay_ticks      <= 16'd500;
            cfg_reg.precharge_timeout_ticks    <= 16'd5000;
            cfg_reg.zero_current_timeout_ticks <= 16'd2000;
            cfg_reg.zero_current_threshold     <= 15'd10;
            cfg_reg.bus_margin                 <= 16'd100;
            cfg_reg.step_settle_ticks          <= 10'd150;
            cfg_reg.close_settle_ticks         <= 10'd100;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/hvcps_step.sv =====
`timescale 1ns / 1ps
// Next-state logic of the sequencer: one item against the current state.
// Depends on hvcps_pkg.

module hvcps_step
(
    input  hvcps_pkg::cfg_t    cfg,
    input  hvcps_pkg::seq_t    cur,
    input  hvcps_pkg::item_t   item,
    output hvcps_pkg::seq_t    nxt,
    output hvcps_pkg::result_t res
);

    logic [15:0] mag;
    logic        zero;
    logic        stable;
    logic [15:0] e1;
    logic        step_done;
    logic        close_done;
    logic        zc_tmo_zero;
    logic        zc_expired;
    logic        pre_ok;
    logic        pre_bus_low;
    logic [15:0] pre_bus;
    logic [2:0]  pre_err;
    logic [3:0]  pre_close_st;
    logic [3:0]  pre_armed_st;
    logic        start_ok;
    logic [2:0]  start_err;
    logic        accepted;

    function automatic logic pre_ok_armed(input logic [3:0] st, input hvcps_pkg::item_t it);
        pre_ok_armed = (st == hvcps_pkg::ST_C_ARMED) ? it.charge_allowed : it.discharge_allowed;
    endfunction

    assign mag  = item.pack_current[15] ? (~item.pack_current + 16'd1) : item.pack_current;
    assign zero = mag < {1'b0, cfg.zero_current_threshold};
    assign e1   = (cur.elapsed == 16'hFFFF) ? cur.elapsed : cur.elapsed + 16'd1;

    assign step_done   = e1 >= {6'd0, cfg.step_settle_ticks};
    assign close_done  = e1 >= {6'd0, cfg.close_settle_ticks};
    assign zc_tmo_zero = cfg.zero_current_timeout_ticks == 16'd0;
    assign zc_expired  = e1 >= cfg.zero_current_timeout_ticks;

    assign pre_ok       = (cur.state == hvcps_pkg::ST_C_PRE) ? item.charge_allowed
                                                             : item.discharge_allowed;
    assign pre_bus      = (cur.state == hvcps_pkg::ST_C_PRE) ? item.charger_bus_voltage
                                                             : item.inverter_bus_voltage;
    assign pre_err      = (cur.state == hvcps_pkg::ST_C_PRE) ? hvcps_pkg::ERR_CHG_ALLOW
                                                             : hvcps_pkg::ERR_DRV_ALLOW;
    assign pre_close_st = (cur.state == hvcps_pkg::ST_C_PRE) ? hvcps_pkg::ST_C_CLOSE
                                                             : hvcps_pkg::ST_D_CLOSE;
    assign pre_armed_st = (cur.state == hvcps_pkg::ST_C_PRE) ? hvcps_pkg::ST_C_ARMED
                                                             : hvcps_pkg::ST_D_ARMED;
    assign pre_bus_low  = ({1'b0, pre_bus} + {1'b0, cfg.bus_margin})
                          < {1'b0, item.pack_voltage};

    assign start_ok  = (item.kind == hvcps_pkg::KIND_START_CHG) ? item.charge_allowed
                                                               : item.discharge_allowed;
    assign start_err = (item.kind == hvcps_pkg::KIND_START_CHG) ? hvcps_pkg::ERR_CHG_ALLOW
                                                               : hvcps_pkg::ERR_DRV_ALLOW;

    assign stable = cur.state inside {hvcps_pkg::ST_OPEN, hvcps_pkg::ST_C_PRE,
                                      hvcps_pkg::ST_C_ARMED, hvcps_pkg::ST_D_PRE,
                                      hvcps_pkg::ST_D_ARMED, hvcps_pkg::ST_ERROR};

    always_comb
    begin
        nxt      = cur;
        accepted = 1'b0;
        if (item.kind == hvcps_pkg::KIND_TICK)
        begin
            nxt.elapsed = e1;
            case (cur.state)
                hvcps_pkg::ST_C_S1:
                begin
                    if (step_done)
                    begin
                        nxt.elapsed = 16'd0;
                        if (cfg.step_settle_ticks == 10'd0)
                        begin
                            nxt.lines = cur.lines | hvcps_pkg::LINE_CHG | hvcps_pkg::LINE_PRE;
                            nxt.state = hvcps_pkg::ST_C_PRE;
                        end
                        else
                        begin
                            nxt.lines = cur.lines | hvcps_pkg::LINE_CHG;
                            nxt.state = hvcps_pkg::ST_C_S2;
                        end
                    end
                end
                hvcps_pkg::ST_C_S2, hvcps_pkg::ST_D_S1:
                begin
                    if (step_done)
                    begin
                        nxt.elapsed = 16'd0;
                        nxt.lines   = cur.lines | hvcps_pkg::LINE_PRE;
                        nxt.state   = (cur.state == hvcps_pkg::ST_C_S2) ? hvcps_pkg::ST_C_PRE
                                                                        : hvcps_pkg::ST_D_PRE;
                    end
                end
                hvcps_pkg::ST_C_CLOSE, hvcps_pkg::ST_D_CLOSE:
                begin
                    if (close_done)
                    begin
                        nxt.elapsed = 16'd0;
                        nxt.lines   = cur.lines & ~hvcps_pkg::LINE_PRE;
                        nxt.state   = (cur.state == hvcps_pkg::ST_C_CLOSE)
                                      ? hvcps_pkg::ST_C_ARMED : hvcps_pkg::ST_D_ARMED;
                    end
                end
                hvcps_pkg::ST_C_PRE, hvcps_pkg::ST_D_PRE:
                begin
                    if (!pre_ok)
                    begin
                        nxt.fault   = pre_err;
                        nxt.lines   = 4'd0;
                        nxt.state   = hvcps_pkg::ST_ERROR;
                        nxt.elapsed = 16'd0;
                    end
                    else if (e1 < cfg.precharge_delay_ticks)
                    begin
                        nxt.elapsed = e1;
                    end
                    else if (pre_bus_low)
                    begin
                        if (e1 >= cfg.precharge_timeout_ticks)
                        begin
                            nxt.fault   = hvcps_pkg::ERR_PRE_TIMEOUT;
                            nxt.lines   = 4'd0;
                            nxt.state   = hvcps_pkg::ST_ERROR;
                            nxt.elapsed = 16'd0;
                        end
                    end
                    else
                    begin
                        nxt.elapsed = 16'd0;
                        if (cfg.close_settle_ticks == 10'd0)
                        begin
                            nxt.lines = (cur.lines | hvcps_pkg::LINE_PLUS) & ~hvcps_pkg::LINE_PRE;
                            nxt.state = pre_armed_st;
                        end
                        else
                        begin
                            nxt.lines = cur.lines | hvcps_pkg::LINE_PLUS;
                            nxt.state = pre_close_st;
                        end
                    end
                end
                hvcps_pkg::ST_C_ARMED, hvcps_pkg::ST_D_ARMED:
                begin
                    if (!pre_ok_armed(cur.state, item))
                    begin
                        if (zc_tmo_zero)
                        begin
                            nxt.fault   = hvcps_pkg::ERR_CURRENT;
                            nxt.lines   = 4'd0;
                            nxt.state   = hvcps_pkg::ST_ERROR;
                            nxt.elapsed = 16'd0;
                        end
                        else if (!zero)
                        begin
                            nxt.state   = cur.state + 4'd1;
                            nxt.elapsed = 16'd0;
                        end
                    end
                end
                hvcps_pkg::ST_C_WAIT, hvcps_pkg::ST_D_WAIT:
                begin
                    if (zc_expired)
                    begin
                        nxt.fault   = hvcps_pkg::ERR_CURRENT;
                        nxt.lines   = 4'd0;
                        nxt.state   = hvcps_pkg::ST_ERROR;
                        nxt.elapsed = 16'd0;
                    end
                    else if (zero)
                    begin
                        nxt.state = cur.state - 4'd1;
                    end
                end
                hvcps_pkg::ST_OPENING:
                begin
                    if (zc_expired || zero)
                    begin
                        nxt.fault   = hvcps_pkg::ERR_NONE;
                        nxt.lines   = 4'd0;
                        nxt.state   = hvcps_pkg::ST_OPEN;
                        nxt.elapsed = 16'd0;
                    end
                end
                default:
                begin
                    nxt.elapsed = e1;
                end
            endcase
        end
        else if (stable)
        begin
            case (item.kind)
                hvcps_pkg::KIND_START_CHG, hvcps_pkg::KIND_START_DRV:
                begin
                    if (cur.state == hvcps_pkg::ST_OPEN)
                    begin
                        nxt.elapsed = 16'd0;
                        if (!start_ok)
                        begin
                            nxt.fault = start_err;
                            nxt.lines = 4'd0;
                            nxt.state = hvcps_pkg::ST_ERROR;
                        end
                        else if (!item.bms_armed)
                        begin
                            nxt.fault = hvcps_pkg::ERR_BMS_ARMED;
                            nxt.lines = 4'd0;
                            nxt.state = hvcps_pkg::ST_ERROR;
                        end
                        else
                        begin
                            accepted = 1'b1;
                            if (cfg.step_settle_ticks != 10'd0)
                            begin
                                nxt.lines = hvcps_pkg::LINE_MINUS;
                                nxt.state = (item.kind == hvcps_pkg::KIND_START_CHG)
                                            ? hvcps_pkg::ST_C_S1 : hvcps_pkg::ST_D_S1;
                            end
                            else if (item.kind == hvcps_pkg::KIND_START_CHG)
                            begin
                                nxt.lines = hvcps_pkg::LINE_MINUS | hvcps_pkg::LINE_CHG
                                            | hvcps_pkg::LINE_PRE;
                                nxt.state = hvcps_pkg::ST_C_PRE;
                            end
                            else
                            begin
                                nxt.lines = hvcps_pkg::LINE_MINUS | hvcps_pkg::LINE_PRE;
                                nxt.state = hvcps_pkg::ST_D_PRE;
                            end
                        end
                    end
                end
                hvcps_pkg::KIND_OPEN:
                begin
                    nxt.elapsed = 16'd0;
                    if (item.immediate || zc_tmo_zero || zero)
                    begin
                        nxt.fault = hvcps_pkg::ERR_NONE;
                        nxt.lines = 4'd0;
                        nxt.state = hvcps_pkg::ST_OPEN;
                    end
                    else
                    begin
                        nxt.state = hvcps_pkg::ST_OPENING;
                    end
                end
                hvcps_pkg::KIND_EMERGENCY:
                begin
                    nxt.fault   = hvcps_pkg::ERR_CURRENT;
                    nxt.lines   = 4'd0;
                    nxt.state   = hvcps_pkg::ST_ERROR;
                    nxt.elapsed = 16'd0;
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
    end

    assign res.lines      = nxt.lines;
    assign res.mode       = nxt.state;
    assign res.error_code = nxt.fault;
    assign res.accepted   = accepted;

endmodule

// ===== sv/hv_contactor_precharge_sequencer_top.sv =====
`timescale 1ns / 1ps
// Top level of the HV contactor precharge sequencer: state registers and output buffer.
// Depends on hvcps_pkg, hvcps_cfg_regs and hvcps_step.

// One item is accepted per clock cycle while in_stall is low; the whole state update
// is a single registered pass through the next-state logic, and the result appears at
// the output in the cycle after acceptance when the output register is empty or being
// read in that cycle, otherwise it waits in the skid register until the one ahead of
// it is read. The output side is a two-entry buffer (output register plus skid
// register), so in_stall rises only when both entries hold undelivered results and
// sustained throughput is one item per cycle whenever the receiver keeps up.
// Configuration writes through the APB port take effect for the next item and should
// be made only while no result is outstanding.

module hv_contactor_precharge_sequencer_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hvcps_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    kind,
    input  logic                          immediate,
    input  logic                          charge_allowed,
    input  logic                          discharge_allowed,
    input  logic                          bms_armed,
    input  logic [15:0]                   pack_voltage,
    input  logic [15:0]                   charger_bus_voltage,
    input  logic [15:0]                   inverter_bus_voltage,
    input  logic signed [15:0]            pack_current,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hv_minus_closed,
    output logic                          hv_plus_closed,
    output logic                          precharge_closed,
    output logic                          charge_closed,
    output logic [3:0]                    mode,
    output logic [2:0]                    error_code,
    output logic                          accepted
);

    hvcps_pkg::cfg_t    cfg;
    hvcps_pkg::item_t   item_in;
    hvcps_pkg::seq_t    seq_reg;
    hvcps_pkg::seq_t    seq_next;
    hvcps_pkg::result_t res_next;
    hvcps_pkg::result_t out_reg;
    hvcps_pkg::result_t skid_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;
    logic               in_take;
    logic               out_take;

    hvcps_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign item_in.kind                 = kind;
    assign item_in.immediate            = immediate;
    assign item_in.charge_allowed       = charge_allowed;
    assign item_in.discharge_allowed    = discharge_allowed;
    assign item_in.bms_armed            = bms_armed;
    assign item_in.pack_voltage         = pack_voltage;
    assign item_in.charger_bus_voltage  = charger_bus_voltage;
    assign item_in.inverter_bus_voltage = inverter_bus_voltage;
    assign item_in.pack_current         = pack_current;

    hvcps_step u_step
    (
        .cfg  (cfg),
        .cur  (seq_reg),
        .item (item_in),
        .nxt  (seq_next),
        .res  (res_next)
    );

    assign in_stall = skid_valid_reg;
    assign in_take  = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg.state   <= hvcps_pkg::ST_OPEN;
            seq_reg.fault   <= hvcps_pkg::ERR_NONE;
            seq_reg.elapsed <= 16'd0;
            seq_reg.lines   <= 4'd0;
        end
        else if (in_take)
        begin
            seq_reg <= seq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_take)
        begin
            out_valid_reg <= 1'b1;
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_take)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_reg <= res_next;
            end
            else
            begin
                skid_reg <= res_next;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign hv_minus_closed  = out_reg.lines[0];
    assign hv_plus_closed   = out_reg.lines[1];
    assign precharge_closed = out_reg.lines[2];
    assign charge_closed    = out_reg.lines[3];
    assign mode             = out_reg.mode;
    assign error_code       = out_reg.error_code;
    assign accepted         = out_reg.accepted;

    // open and error states never drive any contactor
    a_idle_lines_open: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg.state == hvcps_pkg::ST_OPEN || seq_reg.state == hvcps_pkg::ST_ERROR)
        |-> seq_reg.lines == 4'd0)
        else $error("contactor line driven in open or error state");

    // a fault code survives only in error or while opening from error
    a_fault_state: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg.fault != hvcps_pkg::ERR_NONE)
        |-> (seq_reg.state == hvcps_pkg::ST_ERROR || seq_reg.state == hvcps_pkg::ST_OPENING))
        else $error("fault code set outside error handling");

    // skid entry is only ever filled behind a full output register
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output register is empty");

endmodule
